// File: design/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants for the segment pair intersection unit
// Beat layouts for both channels, lane control bundle, saturation limits.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int FIELD_W  = 16;
    localparam int RESULT_W = 32;

    // one input beat: two segments, start and stop points
    typedef struct packed {
        logic signed [FIELD_W-1:0] first_start_x;
        logic signed [FIELD_W-1:0] first_start_y;
        logic signed [FIELD_W-1:0] first_stop_x;
        logic signed [FIELD_W-1:0] first_stop_y;
        logic signed [FIELD_W-1:0] second_start_x;
        logic signed [FIELD_W-1:0] second_start_y;
        logic signed [FIELD_W-1:0] second_stop_x;
        logic signed [FIELD_W-1:0] second_stop_y;
    } t_seg_pair;

    // one output beat
    typedef struct packed {
        logic                       hit;
        logic signed [RESULT_W-1:0] cross_x;
        logic signed [RESULT_W-1:0] cross_y;
    } t_result;

    // control that travels beside one divider lane
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg;
    } t_lane_ctl;

    localparam logic [RESULT_W-1:0] SAT_POS = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RESULT_W-1:0] SAT_NEG = {1'b1, {(RESULT_W-1){1'b0}}};

endpackage

// File: design/spi_geom.sv
// ----------------------------------------------------------------------------
// spi_geom: determinant and crossing numerator pipeline
// Eight stages: sign extension and differences, cross products, determinant,
// sign normalization, strict-inside test, partial products, rejoin, sum, magnitude.
// ----------------------------------------------------------------------------
module spi_geom #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  spi_pkg::t_seg_pair        i_data,
    output spi_pkg::t_lane_ctl        o_ctl_x,
    output spi_pkg::t_lane_ctl        o_ctl_y,
    output logic [3*COORD_BITS+1:0]   o_mag_x,
    output logic [3*COORD_BITS+1:0]   o_mag_y,
    output logic [2*COORD_BITS:0]     o_den
);
    import spi_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int PW  = 2 * C + 2;
    localparam int PPW = 2 * C + 3;
    localparam int NW  = 3 * C + 3;
    localparam int MW  = 3 * C + 2;
    localparam int LW  = C + 1;

    logic signed [FIELD_W-1:0] w_field [8];
    logic signed [C-1:0]       w_crd   [8];

    // valid bits, bit k is stage k+1
    logic [7:0] r_v;

    logic signed [C-1:0]  r_s1_px, r_s1_py;
    logic signed [DW-1:0] r_s1_rx, r_s1_ry, r_s1_sx, r_s1_sy, r_s1_dx, r_s1_dy;

    logic signed [C-1:0]  r_s2_px, r_s2_py;
    logic signed [DW-1:0] r_s2_rx, r_s2_ry;
    logic signed [PW-1:0] r_s2_m0, r_s2_m1, r_s2_m2, r_s2_m3, r_s2_m4, r_s2_m5;

    logic signed [C-1:0]  r_s3_px, r_s3_py;
    logic signed [DW-1:0] r_s3_rx, r_s3_ry;
    logic signed [PW-1:0] r_s3_den, r_s3_tn, r_s3_un;

    logic signed [C-1:0]  r_s4_px, r_s4_py;
    logic signed [DW-1:0] r_s4_rx, r_s4_ry;
    logic signed [PW-1:0] r_s4_den, r_s4_tn, r_s4_un;

    logic signed [LW:0]    w_dlo, w_tlo;
    logic signed [LW-1:0]  w_dhi, w_thi;

    logic                   r_s5_hit;
    logic signed [PW-1:0]   r_s5_den;
    logic signed [PPW-1:0]  r_s5_bdl_x, r_s5_bdh_x, r_s5_rtl_x, r_s5_rth_x;
    logic signed [PPW-1:0]  r_s5_bdl_y, r_s5_bdh_y, r_s5_rtl_y, r_s5_rth_y;

    logic                  r_s6_hit;
    logic signed [PW-1:0]  r_s6_den;
    logic signed [NW-1:0]  r_s6_bd_x, r_s6_rt_x, r_s6_bd_y, r_s6_rt_y;

    logic                  r_s7_hit;
    logic signed [PW-1:0]  r_s7_den;
    logic signed [NW-1:0]  r_s7_num_x, r_s7_num_y;

    logic                  r_s8_hit;
    logic signed [PW-1:0]  r_s8_den;
    logic                  r_s8_neg_x, r_s8_neg_y;
    logic [MW-1:0]         r_s8_mag_x, r_s8_mag_y;

    // unpack the beat
    assign w_field[0] = i_data.first_start_x;
    assign w_field[1] = i_data.first_start_y;
    assign w_field[2] = i_data.first_stop_x;
    assign w_field[3] = i_data.first_stop_y;
    assign w_field[4] = i_data.second_start_x;
    assign w_field[5] = i_data.second_start_y;
    assign w_field[6] = i_data.second_stop_x;
    assign w_field[7] = i_data.second_stop_y;

    // low coordinate bits, sign extended
    generate
        for (genvar g = 0; g < 8; g++) begin : g_sext
            if (C <= FIELD_W) begin : g_trunc
                assign w_crd[g] = w_field[g][C-1:0];
            end else begin : g_ext
                assign w_crd[g] = C'(w_field[g]);
            end
        end
    endgenerate

    // split nonnegative determinant and tn into low and high halves
    assign w_dlo = $signed({1'b0, r_s4_den[LW-1:0]});
    assign w_dhi = $signed(r_s4_den[PW-1:LW]);
    assign w_tlo = $signed({1'b0, r_s4_tn[LW-1:0]});
    assign w_thi = $signed(r_s4_tn[PW-1:LW]);

    // valid shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: points and differences
            r_s1_px <= w_crd[0];
            r_s1_py <= w_crd[1];
            r_s1_rx <= DW'(w_crd[2]) - DW'(w_crd[0]);
            r_s1_ry <= DW'(w_crd[3]) - DW'(w_crd[1]);
            r_s1_sx <= DW'(w_crd[6]) - DW'(w_crd[4]);
            r_s1_sy <= DW'(w_crd[7]) - DW'(w_crd[5]);
            r_s1_dx <= DW'(w_crd[4]) - DW'(w_crd[0]);
            r_s1_dy <= DW'(w_crd[5]) - DW'(w_crd[1]);

            // stage 2: cross product terms
            r_s2_px <= r_s1_px;
            r_s2_py <= r_s1_py;
            r_s2_rx <= r_s1_rx;
            r_s2_ry <= r_s1_ry;
            r_s2_m0 <= r_s1_rx * r_s1_sy;
            r_s2_m1 <= r_s1_ry * r_s1_sx;
            r_s2_m2 <= r_s1_dx * r_s1_sy;
            r_s2_m3 <= r_s1_dy * r_s1_sx;
            r_s2_m4 <= r_s1_dx * r_s1_ry;
            r_s2_m5 <= r_s1_dy * r_s1_rx;

            // stage 3: determinant and both numerators
            r_s3_px  <= r_s2_px;
            r_s3_py  <= r_s2_py;
            r_s3_rx  <= r_s2_rx;
            r_s3_ry  <= r_s2_ry;
            r_s3_den <= r_s2_m0 - r_s2_m1;
            r_s3_tn  <= r_s2_m2 - r_s2_m3;
            r_s3_un  <= r_s2_m4 - r_s2_m5;

            // stage 4: make the determinant nonnegative
            r_s4_px  <= r_s3_px;
            r_s4_py  <= r_s3_py;
            r_s4_rx  <= r_s3_rx;
            r_s4_ry  <= r_s3_ry;
            r_s4_den <= r_s3_den[PW-1] ? -r_s3_den : r_s3_den;
            r_s4_tn  <= r_s3_den[PW-1] ? -r_s3_tn  : r_s3_tn;
            r_s4_un  <= r_s3_den[PW-1] ? -r_s3_un  : r_s3_un;

            // stage 5: strict inside test, numerator partial products
            r_s5_hit   <= (r_s4_tn > PW'(0)) && (r_s4_tn < r_s4_den) &&
                          (r_s4_un > PW'(0)) && (r_s4_un < r_s4_den);
            r_s5_den   <= r_s4_den;
            r_s5_bdl_x <= PPW'(r_s4_px) * PPW'(w_dlo);
            r_s5_bdh_x <= PPW'(r_s4_px) * PPW'(w_dhi);
            r_s5_rtl_x <= PPW'(r_s4_rx) * PPW'(w_tlo);
            r_s5_rth_x <= PPW'(r_s4_rx) * PPW'(w_thi);
            r_s5_bdl_y <= PPW'(r_s4_py) * PPW'(w_dlo);
            r_s5_bdh_y <= PPW'(r_s4_py) * PPW'(w_dhi);
            r_s5_rtl_y <= PPW'(r_s4_ry) * PPW'(w_tlo);
            r_s5_rth_y <= PPW'(r_s4_ry) * PPW'(w_thi);

            // stage 6: rejoin the halves
            r_s6_hit  <= r_s5_hit;
            r_s6_den  <= r_s5_den;
            r_s6_bd_x <= (NW'(r_s5_bdh_x) <<< LW) + NW'(r_s5_bdl_x);
            r_s6_rt_x <= (NW'(r_s5_rth_x) <<< LW) + NW'(r_s5_rtl_x);
            r_s6_bd_y <= (NW'(r_s5_bdh_y) <<< LW) + NW'(r_s5_bdl_y);
            r_s6_rt_y <= (NW'(r_s5_rth_y) <<< LW) + NW'(r_s5_rtl_y);

            // stage 7: base * den + tn * dir
            r_s7_hit   <= r_s6_hit;
            r_s7_den   <= r_s6_den;
            r_s7_num_x <= r_s6_bd_x + r_s6_rt_x;
            r_s7_num_y <= r_s6_bd_y + r_s6_rt_y;

            // stage 8: sign and magnitude for the divider
            r_s8_hit   <= r_s7_hit;
            r_s8_den   <= r_s7_den;
            r_s8_neg_x <= r_s7_num_x[NW-1];
            r_s8_neg_y <= r_s7_num_y[NW-1];
            r_s8_mag_x <= MW'(r_s7_num_x[NW-1] ? -r_s7_num_x : r_s7_num_x);
            r_s8_mag_y <= MW'(r_s7_num_y[NW-1] ? -r_s7_num_y : r_s7_num_y);
        end
    end

    assign o_ctl_x = '{valid: r_v[7], hit: r_s8_hit, neg: r_s8_neg_x};
    assign o_ctl_y = '{valid: r_v[7], hit: r_s8_hit, neg: r_s8_neg_y};
    assign o_mag_x = r_s8_mag_x;
    assign o_mag_y = r_s8_mag_y;
    assign o_den   = r_s8_den[2*C:0];

`ifndef NO_ASSERTIONS
    // determinant is never negative once normalized
    a_den_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> !r_s4_den[PW-1])
        else $error("normalized determinant is negative");

    // a hit never comes with a zero determinant
    a_hit_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && r_s5_hit) |-> (r_s5_den != PW'(0)))
        else $error("hit with zero determinant");
`endif

endmodule

// File: design/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div: pipelined restoring divider
// One quotient bit per stage; the dividend is the numerator magnitude scaled
// by the fraction bits, the divisor is the positive determinant.
// ----------------------------------------------------------------------------
module spi_div #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  spi_pkg::t_lane_ctl                  i_ctl,
    input  logic [3*COORD_BITS+1:0]             i_mag,
    input  logic [2*COORD_BITS:0]               i_den,
    output spi_pkg::t_lane_ctl                  o_ctl,
    output logic [COORD_BITS+FRAC_BITS-1:0]     o_quo
);
    import spi_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int QB  = COORD_BITS + FRAC_BITS;
    localparam int RW  = 2 * C + 2;
    localparam int DNW = 2 * C + 1;

    t_lane_ctl        r_ctl [QB+1];
    logic [RW-1:0]    r_rem [QB+1];
    logic [QB-1:0]    r_quo [QB+1];
    logic [C-1:0]     r_mag [QB+1];
    logic [DNW-1:0]   r_den [QB+1];

    // control shift with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k <= QB; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // entry stage: upper dividend bits seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_mag >> C);
            r_quo[0] <= '0;
            r_mag[0] <= i_mag[C-1:0];
            r_den[0] <= i_den;
        end
    end

    // one quotient bit per stage
    generate
        for (genvar k = 1; k <= QB; k++) begin : g_step
            localparam int BI = QB - k;
            logic          w_nb;
            logic [RW-1:0] w_t;
            logic          w_ge;

            if (BI >= FRAC_BITS) begin : g_bit
                assign w_nb = r_mag[k-1][BI-FRAC_BITS];
            end else begin : g_zero
                assign w_nb = 1'b0;
            end

            assign w_t  = {r_rem[k-1][RW-2:0], w_nb};
            assign w_ge = w_t >= {1'b0, r_den[k-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_t - {1'b0, r_den[k-1]} : w_t;
                    r_quo[k] <= {r_quo[k-1][QB-2:0], w_ge};
                    r_mag[k] <= r_mag[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    endgenerate

    assign o_ctl = r_ctl[QB];
    assign o_quo = r_quo[QB];

`ifndef NO_ASSERTIONS
    // final remainder of a hit is below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl[QB].valid && r_ctl[QB].hit) |-> (r_rem[QB] < {1'b0, r_den[QB]}))
        else $error("divider remainder out of range");
`endif

endmodule

// File: design/segment_pair_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_pair_intersection_unit: strict segment crossing test and point
// Takes one pair of segments per beat and returns hit plus the crossing point
// in signed fixed point, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
// The unit accepts one segment pair every clock while o_ready is high and
// returns one result beat per input beat, in order. The pipeline holds
// eight stages of determinant and numerator arithmetic, an entry stage plus
// one stage per quotient bit in the restoring divider, and the output
// register; the divider's quotient width sets most of its depth.
// A miss (parallel, collinear, or crossing on or beyond an endpoint) returns
// hit low with both coordinates zero. A stall at the output holds the
// pipeline, but an empty final stage still lets new beats in.
module segment_pair_intersection_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  spi_pkg::t_seg_pair i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output spi_pkg::t_result   o_data
);
    import spi_pkg::*;

    localparam int QB = COORD_BITS + FRAC_BITS;
    localparam int SW = (QB > RESULT_W + 1) ? QB : RESULT_W + 1;

    logic                      w_en;
    t_lane_ctl                 w_gctl_x, w_gctl_y;
    logic [3*COORD_BITS+1:0]   w_mag_x, w_mag_y;
    logic [2*COORD_BITS:0]     w_den;
    t_lane_ctl                 w_ctl_x, w_ctl_y;
    logic [QB-1:0]             w_quo_x, w_quo_y;
    t_result                   w_res;

    logic                      r_out_valid;
    t_result                   r_out_data;

    // clamp a signed magnitude into the result width
    function automatic logic [RESULT_W-1:0] f_sat(input logic neg,
                                                  input logic [SW-1:0] q);
        logic [RESULT_W-1:0] res;
        if (neg) begin
            if (q > SW'(SAT_NEG)) begin
                res = SAT_NEG;
            end else begin
                res = RESULT_W'(SW'(0) - q);
            end
        end else begin
            if (q > SW'(SAT_POS)) begin
                res = SAT_POS;
            end else begin
                res = RESULT_W'(q);
            end
        end
        return res;
    endfunction

    // pipeline advances unless a held result would be overwritten
    assign w_en    = !r_out_valid || i_ready || !w_ctl_x.valid;
    assign o_ready = w_en;

    spi_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ctl_x (w_gctl_x),
        .o_ctl_y (w_gctl_y),
        .o_mag_x (w_mag_x),
        .o_mag_y (w_mag_y),
        .o_den   (w_den)
    );

    spi_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_gctl_x),
        .i_mag   (w_mag_x),
        .i_den   (w_den),
        .o_ctl   (w_ctl_x),
        .o_quo   (w_quo_x)
    );

    spi_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_gctl_y),
        .i_mag   (w_mag_y),
        .i_den   (w_den),
        .o_ctl   (w_ctl_y),
        .o_quo   (w_quo_y)
    );

    // result beat, zero on a miss
    always_comb begin
        w_res.hit = w_ctl_x.hit;
        if (w_ctl_x.hit) begin
            w_res.cross_x = f_sat(w_ctl_x.neg, SW'(w_quo_x));
            w_res.cross_y = f_sat(w_ctl_y.neg, SW'(w_quo_y));
        end else begin
            w_res.cross_x = '0;
            w_res.cross_y = '0;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= w_ctl_x.valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out_data <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef NO_ASSERTIONS
    // a miss reports a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.hit) |-> (o_data.cross_x == '0 && o_data.cross_y == '0))
        else $error("miss with nonzero crossing point");

    // both divider lanes stay in step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl_x.valid || w_ctl_y.valid) |->
            (w_ctl_x.valid == w_ctl_y.valid && w_ctl_x.hit == w_ctl_y.hit))
        else $error("divider lanes out of step");
`endif

endmodule
